FILE: src/ctok_pkg.sv
// Package of the C token scanner: token kinds, character codes and the result item type.
`default_nettype none
package ctok_pkg;

	localparam int DEF_POSITION_BITS = 16;
	localparam int SLOTS = 3;

	// Token kinds as reported on the result channel.
	localparam logic [4:0] KIND_INVALID  = 5'd0;
	localparam logic [4:0] KIND_NEWLINE  = 5'd1;
	localparam logic [4:0] KIND_END      = 5'd2;
	localparam logic [4:0] KIND_IDENT    = 5'd3;
	localparam logic [4:0] KIND_NUMBER   = 5'd4;
	localparam logic [4:0] KIND_PLUS     = 5'd5;
	localparam logic [4:0] KIND_INC      = 5'd6;
	localparam logic [4:0] KIND_PLUS_EQ  = 5'd7;
	localparam logic [4:0] KIND_MINUS    = 5'd8;
	localparam logic [4:0] KIND_DEC      = 5'd9;
	localparam logic [4:0] KIND_ARROW    = 5'd10;
	localparam logic [4:0] KIND_MINUS_EQ = 5'd11;
	localparam logic [4:0] KIND_LPAREN   = 5'd12;
	localparam logic [4:0] KIND_RPAREN   = 5'd13;
	localparam logic [4:0] KIND_LBRACE   = 5'd14;
	localparam logic [4:0] KIND_RBRACE   = 5'd15;
	localparam logic [4:0] KIND_SEMI     = 5'd16;
	localparam logic [4:0] KIND_ASSIGN   = 5'd17;

	// Kind of the token still open at the end of the last byte.
	localparam logic [2:0] PEND_NONE   = 3'd0;
	localparam logic [2:0] PEND_IDENT  = 3'd1;
	localparam logic [2:0] PEND_NUMBER = 3'd2;
	localparam logic [2:0] PEND_PLUS   = 3'd3;
	localparam logic [2:0] PEND_MINUS  = 3'd4;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef struct packed {
		logic [4:0]  token_kind;
		logic [15:0] start_row;
		logic [15:0] start_column;
		logic [7:0]  leading_spaces;
		logic [7:0]  token_length;
		logic        last;
	} res_t;

	// Results caused by one byte, in order, and how many of them are valid.
	typedef struct packed {
		res_t [SLOTS-1:0] slot;
		logic [1:0]       count;
	} step_out_t;

endpackage
`default_nettype wire

FILE: src/ctok_char_if.sv
// Valid/ready channel that carries one source byte per item.
`default_nettype none
interface ctok_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink (input valid, input char_code, output ready);
endinterface
`default_nettype wire

FILE: src/ctok_token_if.sv
// Valid/ready channel that carries one token report per item.
`default_nettype none
interface ctok_token_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [15:0] start_row;
	logic [15:0] start_column;
	logic [7:0]  leading_spaces;
	logic [7:0]  token_length;
	logic        last;

	modport source (output valid, output token_kind, output start_row, output start_column,
		output leading_spaces, output token_length, output last, input ready);
	modport sink (input valid, input token_kind, input start_row, input start_column,
		input leading_spaces, input token_length, input last, output ready);
endinterface
`default_nettype wire

FILE: src/ctok_scan.sv
// Scanner state and the single-byte step that classifies a byte and forms its token reports.
`default_nettype none
module ctok_scan #(
	parameter int POSITION_BITS = ctok_pkg::DEF_POSITION_BITS
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic [7:0]          char_code,
	output ctok_pkg::step_out_t      result
);

	localparam int P = POSITION_BITS;
	localparam logic [P-1:0] POS_ONE = {{(P-1){1'b0}}, 1'b1};
	localparam logic [P-1:0] POS_MAX = {P{1'b1}};

	typedef struct packed {
		logic [2:0]   pend;
		logic [P-1:0] row;
		logic [P-1:0] col;
		logic [P-1:0] trow;
		logic [P-1:0] tcol;
		logic [7:0]   spc;
		logic [7:0]   len;
	} st_t;

	localparam st_t ST_RESET = '{pend: ctok_pkg::PEND_NONE, row: POS_ONE, col: POS_ONE,
		trow: POS_ONE, tcol: POS_ONE, spc: 8'd0, len: 8'd0};

	function automatic logic [P-1:0] pinc(input logic [P-1:0] v);
		pinc = (v == POS_MAX) ? v : v + POS_ONE;
	endfunction

	function automatic logic [7:0] sinc(input logic [7:0] v);
		sinc = (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		is_alpha = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= 8'h30 && c <= 8'h39);
	endfunction

	function automatic ctok_pkg::res_t mk(input st_t s, input logic [4:0] k,
		input logic [7:0] l);
		mk = '{token_kind: k, start_row: 16'(s.trow), start_column: 16'(s.tcol),
			leading_spaces: s.spc, token_length: l, last: 1'b0};
	endfunction

	// One character through the scanner: extends the open token if it can, else closes it
	// and then starts, skips or reports on the character itself.
	task automatic take_char(input st_t s, input logic [7:0] c, output st_t ns,
		output ctok_pkg::res_t r0, output ctok_pkg::res_t r1, output logic [1:0] cnt);
		logic           done;
		logic           ext;
		logic [4:0]     k;
		logic           new_emit;
		logic [4:0]     new_kind;
		logic [7:0]     new_len;
		ctok_pkg::res_t e;
		ns = s;
		r0 = '0;
		r1 = '0;
		cnt = 2'd0;
		done = 1'b0;
		ext = 1'b0;
		k = ctok_pkg::KIND_INVALID;
		new_emit = 1'b0;
		new_kind = ctok_pkg::KIND_INVALID;
		new_len = 8'd0;
		e = '0;

		if (s.pend == ctok_pkg::PEND_IDENT || s.pend == ctok_pkg::PEND_NUMBER) begin
			ext = is_alpha(c) || is_digit(c) || (s.pend == ctok_pkg::PEND_IDENT &&
				(c == ctok_pkg::CH_UNDER || c == ctok_pkg::CH_DOLLAR));
			if (ext) begin
				ns.len = sinc(ns.len);
				ns.col = pinc(ns.col);
				done = 1'b1;
			end else begin
				r0 = mk(ns, (s.pend == ctok_pkg::PEND_IDENT) ? ctok_pkg::KIND_IDENT :
					ctok_pkg::KIND_NUMBER, ns.len);
				cnt = 2'd1;
				ns.spc = 8'd0;
				ns.pend = ctok_pkg::PEND_NONE;
			end
		end else if (s.pend == ctok_pkg::PEND_PLUS || s.pend == ctok_pkg::PEND_MINUS) begin
			if (s.pend == ctok_pkg::PEND_PLUS) begin
				k = (c == ctok_pkg::CH_PLUS) ? ctok_pkg::KIND_INC :
					(c == ctok_pkg::CH_EQ) ? ctok_pkg::KIND_PLUS_EQ : ctok_pkg::KIND_INVALID;
			end else begin
				k = (c == ctok_pkg::CH_MINUS) ? ctok_pkg::KIND_DEC :
					(c == ctok_pkg::CH_GT) ? ctok_pkg::KIND_ARROW :
					(c == ctok_pkg::CH_EQ) ? ctok_pkg::KIND_MINUS_EQ : ctok_pkg::KIND_INVALID;
			end
			if (k != ctok_pkg::KIND_INVALID) begin
				r0 = mk(ns, k, 8'd2);
				cnt = 2'd1;
				ns.spc = 8'd0;
				ns.pend = ctok_pkg::PEND_NONE;
				ns.col = pinc(ns.col);
				done = 1'b1;
			end else begin
				r0 = mk(ns, (s.pend == ctok_pkg::PEND_PLUS) ? ctok_pkg::KIND_PLUS :
					ctok_pkg::KIND_MINUS, 8'd1);
				cnt = 2'd1;
				ns.spc = 8'd0;
				ns.pend = ctok_pkg::PEND_NONE;
			end
		end else begin
			ns.pend = ctok_pkg::PEND_NONE;
		end

		if (!done) begin
			if (c == ctok_pkg::CH_SPACE) begin
				ns.spc = sinc(ns.spc);
				ns.col = pinc(ns.col);
			end else begin
				ns.trow = ns.row;
				ns.tcol = ns.col;
				if (c == ctok_pkg::CH_NL) begin
					new_emit = 1'b1;
					new_kind = ctok_pkg::KIND_NEWLINE;
					ns.row = pinc(ns.row);
					ns.col = POS_ONE;
				end else if (c == ctok_pkg::CH_NUL) begin
					new_emit = 1'b1;
					new_kind = ctok_pkg::KIND_END;
				end else begin
					ns.len = 8'd1;
					new_len = 8'd1;
					if (c == ctok_pkg::CH_PLUS) begin
						ns.pend = ctok_pkg::PEND_PLUS;
					end else if (c == ctok_pkg::CH_MINUS) begin
						ns.pend = ctok_pkg::PEND_MINUS;
					end else if (is_alpha(c) || c == ctok_pkg::CH_UNDER ||
						c == ctok_pkg::CH_DOLLAR) begin
						ns.pend = ctok_pkg::PEND_IDENT;
					end else if (is_digit(c)) begin
						ns.pend = ctok_pkg::PEND_NUMBER;
					end else begin
						new_emit = 1'b1;
						unique case (c)
							ctok_pkg::CH_LPAREN: new_kind = ctok_pkg::KIND_LPAREN;
							ctok_pkg::CH_RPAREN: new_kind = ctok_pkg::KIND_RPAREN;
							ctok_pkg::CH_LBRACE: new_kind = ctok_pkg::KIND_LBRACE;
							ctok_pkg::CH_RBRACE: new_kind = ctok_pkg::KIND_RBRACE;
							ctok_pkg::CH_SEMI:   new_kind = ctok_pkg::KIND_SEMI;
							ctok_pkg::CH_EQ:     new_kind = ctok_pkg::KIND_ASSIGN;
							default:             new_kind = ctok_pkg::KIND_INVALID;
						endcase
					end
					ns.col = pinc(ns.col);
				end
				if (new_emit) begin
					e = mk(ns, new_kind, new_len);
					if (cnt == 2'd0) begin
						r0 = e;
					end else begin
						r1 = e;
					end
					cnt = cnt + 2'd1;
					ns.spc = 8'd0;
				end
				if (c == ctok_pkg::CH_NUL) begin
					ns = ST_RESET;
				end
			end
		end
	endtask

	st_t              st_q;
	logic             bs_held_q;
	st_t              st_bs;
	st_t              st_mid;
	st_t              st_ch;
	st_t              st_next;
	ctok_pkg::res_t   a0, a1, b0, b1;
	logic [1:0]       n1, n2, n1_eff, n2_eff, total;
	logic             splice;
	logic             use_bs;
	logic             bs_next;
	ctok_pkg::res_t [ctok_pkg::SLOTS-1:0] slots;

	always_comb begin
		// A held backslash is either a splice (dropped with the newline) or a lone
		// backslash that is scanned as an ordinary character ahead of this byte.
		splice = bs_held_q && (char_code == ctok_pkg::CH_NL);
		use_bs = bs_held_q && !splice;
		take_char(st_q, ctok_pkg::CH_BSLASH, st_bs, a0, a1, n1);
		st_mid = use_bs ? st_bs : st_q;
		n1_eff = use_bs ? n1 : 2'd0;
		take_char(st_mid, char_code, st_ch, b0, b1, n2);
		bs_next = !splice && (char_code == ctok_pkg::CH_BSLASH);
		n2_eff = (splice || bs_next) ? 2'd0 : n2;

		if (splice) begin
			st_next = st_q;
			st_next.row = pinc(st_q.row);
			st_next.col = POS_ONE;
		end else if (bs_next) begin
			st_next = st_mid;
		end else begin
			st_next = st_ch;
		end

		unique case (n1_eff)
			2'd0: slots = {ctok_pkg::res_t'('0), b1, b0};
			2'd1: slots = {b1, b0, a0};
			2'd2: slots = {b0, a1, a0};
			default: slots = {b0, a1, a0};
		endcase
		total = n1_eff + n2_eff;
		if (total != 2'd0) begin
			slots[total - 2'd1].last = 1'b1;
		end
		result.slot = slots;
		result.count = total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RESET;
			bs_held_q <= 1'b0;
		end else if (en) begin
			st_q <= st_next;
			bs_held_q <= bs_next;
		end
	end

endmodule
`default_nettype wire

FILE: src/c_token_scanner_top.sv
// Top level of the C token scanner: input register, per-byte result buffer and output register.
`default_nettype none
// The scanner takes source text one byte per item on the chars channel and reports each
// token on the tokens channel once the token has ended, with its kind, start row and
// column, the spaces before it and its length. A byte is registered on acceptance and
// scanned from the input register once the buffer can take its reports; its reports
// (none, one, two or three) are loaded into a three-entry buffer that drains one report
// per cycle into the output register while that register is free or being taken. A byte
// that causes at most one report lets ordinary text stream at one byte per cycle while
// the tokens channel does not stall; a byte that causes more reports holds the input
// because the buffer must have emptied before the next byte can load it. Row and column
// counters are POSITION_BITS wide internally and reported in their low 16 bits.
module c_token_scanner_top #(
	parameter int POSITION_BITS = ctok_pkg::DEF_POSITION_BITS
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	ctok_char_if.sink      chars,
	ctok_token_if.source   tokens
);

	// Input register.
	logic       valid_s1;
	logic [7:0] char_s1;

	// Reports of the last scanned byte, read out in order from the head.
	ctok_pkg::res_t buf_q [ctok_pkg::SLOTS];
	logic [1:0]     buf_cnt_q;
	logic [1:0]     buf_head_q;

	// Output register.
	logic           ov_q;
	ctok_pkg::res_t oitem_q;

	ctok_pkg::step_out_t step;
	logic move;
	logic buf_drain;
	logic adv;

	// A report moves out when the output register is free or is being taken.
	assign move = (buf_cnt_q != 2'd0) && (!ov_q || tokens.ready);
	// The buffer can take a new byte's reports when it is empty by the end of this cycle.
	assign buf_drain = (buf_cnt_q == 2'd0) || ((buf_cnt_q == 2'd1) && move);
	assign adv = valid_s1 && buf_drain;
	assign chars.ready = !valid_s1 || adv;

	ctok_scan #(
		.POSITION_BITS(POSITION_BITS)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.char_code (char_s1),
		.result    (step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_cnt_q <= 2'd0;
			buf_head_q <= 2'd0;
		end else if (adv) begin
			buf_cnt_q <= step.count;
			buf_head_q <= 2'd0;
		end else if (move) begin
			buf_cnt_q <= buf_cnt_q - 2'd1;
			buf_head_q <= (buf_head_q == 2'(ctok_pkg::SLOTS - 1)) ? 2'd0 :
				buf_head_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < ctok_pkg::SLOTS; i++) begin
				buf_q[i] <= step.slot[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (move) begin
			ov_q <= 1'b1;
		end else if (tokens.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			oitem_q <= buf_q[buf_head_q];
		end
	end

	assign tokens.valid          = ov_q;
	assign tokens.token_kind     = oitem_q.token_kind;
	assign tokens.start_row      = oitem_q.start_row;
	assign tokens.start_column   = oitem_q.start_column;
	assign tokens.leading_spaces = oitem_q.leading_spaces;
	assign tokens.token_length   = oitem_q.token_length;
	assign tokens.last           = oitem_q.last;

	// A new byte never overwrites reports that have not yet moved out.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && buf_cnt_q != 2'd0) |-> (move && buf_cnt_q == 2'd1))
		else $error("result buffer overwritten before it drained");

	// The head never runs past the reports that were loaded.
	a_head_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, buf_head_q} + {1'b0, buf_cnt_q}) <= 3'(ctok_pkg::SLOTS))
		else $error("result buffer head out of range");

	// The final report of every byte carries the last flag.
	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && step.count != 2'd0) |-> step.slot[step.count - 2'd1].last)
		else $error("final report of a byte lacks the last flag");

	// When a byte causes three reports, only the final one carries the last flag.
	a_last_only_final: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && step.count == 2'd3) |-> (!step.slot[0].last && !step.slot[1].last))
		else $error("last flag set on an earlier report");

endmodule
`default_nettype wire
